// File: hdl/stm_pkg.sv
// shared types and constants of the scotopic tone map pixel unit
// no dependencies; imported by stm_div, scotopic_tone_map_pixel_unit and tb_top
`default_nettype none

package stm_pkg;

  localparam int unsigned DW = 32;

  // fixed-point coefficients, unsigned Q1.16
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [15:0] C_NEG_X = 16'd46006;
  localparam logic [16:0] C_Y     = 17'd68092;
  localparam logic [14:0] C_Z     = 15'd28377;
  localparam logic [14:0] C_03    = 15'd19661;
  localparam logic [14:0] C_04    = 15'd26214;

  // pipelined divider for (Y << 16) / y
  localparam int unsigned QUO_W      = 48;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_BITS;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONE_SCALE,
    CFG_ROD_SCALE,
    CFG_ROD_BLEND,
    CFG_DISPLAY_MAX_RECIP
  } cfg_idx_e;

  typedef struct packed {
    logic          func;
    logic [DW-1:0] comp_a;
    logic [DW-1:0] comp_b;
    logic [DW-1:0] comp_c;
  } pix_in_t;

  typedef struct packed {
    logic [DW-1:0] res_a;
    logic [DW-1:0] res_b;
    logic [DW-1:0] res_c;
    logic          saturated;
  } pix_out_t;

endpackage

`default_nettype wire

// File: hdl/stm_div.sv
// pipelined restoring divider, {dividend, 16 zero bits} / divisor
// depends on stm_pkg (quotient width, bits per stage)
`default_nettype none

module stm_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [stm_pkg::DW-1:0]    dividend_i,
  input  logic [stm_pkg::DW-1:0]    divisor_i,
  output logic [stm_pkg::QUO_W-1:0] quot_o
);
  import stm_pkg::*;

  logic [DW-1:0]    rem_q [DIV_STAGES];
  logic [DW-1:0]    rem_d [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_d [DIV_STAGES];
  logic [QUO_W-1:0] num_q [DIV_STAGES];
  logic [QUO_W-1:0] num_d [DIV_STAGES];
  logic [DW-1:0]    den_q [DIV_STAGES];
  logic [DW-1:0]    den_d [DIV_STAGES];

  // one restoring step: shift in a bit, subtract when it fits
  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nb,
                                           input logic [DW-1:0] den);
    logic [DW:0] t;
    logic [DW:0] d;
    logic [DW:0] diff;
    t    = {rem, nb};
    d    = {1'b0, den};
    diff = t - d;
    if (t >= d) begin
      return {1'b1, diff[DW-1:0]};
    end
    return {1'b0, t[DW-1:0]};
  endfunction

  always_comb begin
    logic [DW-1:0]    r;
    logic [QUO_W-1:0] q;
    logic [QUO_W-1:0] n;
    logic [DW-1:0]    d;
    logic [DW:0]      st;
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (j == 0) begin
        r = '0;
        q = '0;
        n = {dividend_i, {(QUO_W-DW){1'b0}}};
        d = divisor_i;
      end else begin
        r = rem_q[j-1];
        q = quo_q[j-1];
        n = num_q[j-1];
        d = den_q[j-1];
      end
      for (int i = 0; i < DIV_BITS; i++) begin
        st = div_step(r, n[QUO_W-1], d);
        r  = st[DW-1:0];
        q  = {q[QUO_W-2:0], st[DW]};
        n  = {n[QUO_W-2:0], 1'b0};
      end
      rem_d[j] = r;
      quo_d[j] = q;
      num_d[j] = n;
      den_d[j] = d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
        num_q[j] <= num_d[j];
        den_q[j] <= den_d[j];
      end
    end
  end

  assign quot_o = quo_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: hdl/scotopic_tone_map_pixel_unit.sv
// scotopic tone map pixel unit: rod/cone blended tone mapping, one pixel per clock while not stalled
// depends on stm_pkg and stm_div
// datapath: input register, then the 24-stage divider of Y by y (2 quotient bits per stage) and the split
//   products, then the result register and the output register
// throughput: one transaction per cycle; the input stalls only while the one-entry skid holds a result
// reset: clears valid bits, skid and output valid, and loads the register defaults
`default_nettype none

module scotopic_tone_map_pixel_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stm_pkg::DW-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  stm_pkg::pix_in_t              in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output stm_pkg::pix_out_t             out_o
);
  import stm_pkg::*;

  // stage numbers; the divider output register is stage P
  localparam int unsigned P    = 1 + DIV_STAGES;
  localparam int unsigned LAST = P + 11;

  // configuration registers and derived weights
  logic [DW-1:0] cone_q, rod_q, dmr_q;
  logic [16:0]   blend_q;
  logic [16:0]   k_q;
  logic [DW-1:0] cw_q, rw_q;
  logic [16:0]   k_d;
  logic [48:0]   cw_full, rw_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cone_q  <= 32'd65536;
      rod_q   <= 32'd65536;
      blend_q <= 17'd65536;
      dmr_q   <= 32'd167772;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CONE_SCALE:        cone_q  <= cfg_data_i;
        CFG_ROD_SCALE:         rod_q   <= cfg_data_i;
        CFG_ROD_BLEND:         blend_q <= cfg_data_i[16:0];
        CFG_DISPLAY_MAX_RECIP: dmr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // blend clamps at one; the weights are registered from k_q, itself registered from the clamped blend
  assign k_d     = (blend_q > ONE_Q16) ? ONE_Q16 : blend_q;
  assign cw_full = 49'(ONE_Q16 - k_q) * 49'(cone_q);
  assign rw_full = 49'(k_q) * 49'(rod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= ONE_Q16;
      cw_q <= '0;
      rw_q <= 32'd65536;
    end else begin
      k_q  <= k_d;
      cw_q <= cw_full[47:16];
      rw_q <= rw_full[47:16];
    end
  end

  // pipeline advance: stalls only while the skid holds a result
  logic     adv;
  logic     sv_q, ov_q;
  logic     take;
  pix_out_t od_q, sd_q;
  logic [LAST:1] v_q;
  pix_in_t  base_q [1:LAST-1];

  assign adv        = !sv_q;
  assign in_ready_o = adv;
  assign take       = ov_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[LAST-1:1], in_valid_i};
    end
  end

  // divider of Y << 16 by y, stages 2 to P
  logic [QUO_W-1:0] quo;

  stm_div u_div (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (base_q[1].comp_c),
    .divisor_i  (base_q[1].comp_b),
    .quot_o     (quo)
  );

  // xyY rod weight w = -0.702x + 0.433(1-x-y)
  logic [47:0]        wa_d, wa_q;
  logic signed [34:0] wt_t;
  logic signed [49:0] wt_d, wt_q;
  logic signed [50:0] w_full;
  logic [48:0]        wabs_d, wabs_q;
  logic               wneg_d, wneg_q;

  // q * |w| >> 32 in four partial products
  logic [63:0] p00_d, p00_q;
  logic [48:0] p01_d, p01_q;
  logic [47:0] p10_d, p10_q;
  logic [32:0] p11_d, p11_q, p11b_q;
  logic        wneg1_q, wneg2_q, wneg3_q;
  logic [50:0] m_d, m_q;
  logic [65:0] v_full;
  logic [63:0] mq_d, mq_q;
  logic        satw_d, satw_q;
  logic [48:0] yprod;
  logic [32:0] yterm_q;

  // rod response, then r * rod_scale and * k
  logic [64:0] rsum;
  logic [63:0] r_d, r_q;
  logic        rsat_d, rsat_q, sat5_q, sat6_q, sat7_q, sat8_q;
  logic [63:0] pr0_d, pr0_q, pr1_d, pr1_q;
  logic [80:0] f_full;
  logic [63:0] rr_d, rr_q;
  logic [48:0] lk0_d, lk0_q, lk1_d, lk1_q;
  logic [81:0] lsum;
  logic [63:0] lds_q;
  logic [63:0] cprod;
  logic [47:0] ldp_q;
  logic [64:0] lum;

  // XYZ path
  logic [47:0]        m0pa_d, m0pa_q;
  logic [48:0]        m0pb_d, m0pb_q;
  logic [46:0]        m0pc_d, m0pc_q;
  logic signed [50:0] rs;
  logic [32:0]        r0_d, r0_q;
  logic [47:0]        s3p, s4p;
  logic [DW-1:0]      s3_q, s4_q;
  logic [63:0]        pcwa, pcwb, pcwc, prap, prcp;
  logic [47:0]        pcwa_q, pcwb_q, pcwc_q, pra_q, prc_q;

  // shared output scaling by display_max_recip
  logic [63:0] fin_d [3];
  logic [63:0] fin_q [3];
  logic        psat_d, psat_q, psat2_q;
  logic [63:0] plo_q [3];
  logic [63:0] phi_q [3];
  logic [49:0] cha_d, chb_d;
  logic [33:0] cha_q, chb_q;
  logic [96:0] full [3];
  logic [DW-1:0] mapped [3];
  logic [2:0]  clip;
  logic [DW-1:0] sxa, sxb;
  logic        clip_xa, clip_xb;
  pix_out_t    res_d, res_q;
  pix_in_t     fb;

  always_comb begin
    // stage P-1
    wa_d = 48'(C_NEG_X) * 48'(base_q[P-2].comp_a);
    wt_t = $signed({18'b0, ONE_Q16}) - $signed({3'b0, base_q[P-2].comp_a})
         - $signed({3'b0, base_q[P-2].comp_b});
    wt_d = 50'(wt_t) * $signed({35'b0, C_Z});
    // stage P
    w_full = 51'(wt_q) - $signed({3'b0, wa_q});
    wneg_d = w_full[50];
    wabs_d = wneg_d ? 49'(-w_full) : 49'(w_full);
    // stage P+1
    p00_d = 64'(quo[31:0]) * 64'(wabs_q[31:0]);
    p01_d = 49'(quo[31:0]) * 49'(wabs_q[48:32]);
    p10_d = 48'(quo[47:32]) * 48'(wabs_q[31:0]);
    p11_d = 33'(quo[47:32]) * 33'(wabs_q[48:32]);
    // stage P+2
    m_d = 51'(p00_q[63:32]) + 51'(p01_q) + 51'(p10_q);
    // stage P+3
    v_full = 66'({p11b_q, 32'b0}) + 66'(m_q);
    satw_d = |v_full[65:64];
    mq_d   = satw_d ? '1 : v_full[63:0];
    yprod  = 49'(C_Y) * 49'(base_q[P+2].comp_c);
    // stage P+4: add the weighted term saturating, or subtract it clamped at zero
    rsum = 65'(yterm_q) + 65'(mq_q);
    if (!wneg3_q) begin
      rsat_d = satw_q | rsum[64];
      r_d    = rsat_d ? '1 : rsum[63:0];
    end else begin
      rsat_d = satw_q;
      r_d    = (mq_q > 64'(yterm_q)) ? '0 : 64'(yterm_q) - mq_q;
    end
    // stage P+5
    pr0_d  = 64'(r_q[31:0]) * 64'(rod_q);
    pr1_d  = 64'(r_q[63:32]) * 64'(rod_q);
    m0pa_d = 48'(C_NEG_X) * 48'(base_q[P+4].comp_a);
    m0pb_d = 49'(C_Y) * 49'(base_q[P+4].comp_b);
    m0pc_d = 47'(C_Z) * 47'(base_q[P+4].comp_c);
    // stage P+6
    f_full = 81'({pr1_q, 16'b0}) + 81'(pr0_q[63:16]);
    rr_d   = (|f_full[80:64]) ? '1 : f_full[63:0];
    rs     = $signed({2'b0, m0pb_q}) + $signed({4'b0, m0pc_q}) - $signed({3'b0, m0pa_q});
    r0_d   = rs[50] ? '0 : rs[48:16];
    // stage P+7
    lk0_d = 49'(rr_q[31:0]) * 49'(k_q);
    lk1_d = 49'(rr_q[63:32]) * 49'(k_q);
    s3p   = 48'(r0_q) * 48'(C_03);
    s4p   = 48'(r0_q) * 48'(C_04);
    // stage P+8
    lsum  = 82'({lk1_q, 32'b0}) + 82'(lk0_q);
    cprod = 64'(base_q[P+7].comp_c) * 64'(cone_q);
    pcwa  = 64'(base_q[P+7].comp_a) * 64'(cw_q);
    pcwb  = 64'(base_q[P+7].comp_b) * 64'(cw_q);
    pcwc  = 64'(base_q[P+7].comp_c) * 64'(cw_q);
    prap  = 64'(s3_q) * 64'(rw_q);
    prcp  = 64'(s4_q) * 64'(rw_q);
    // stage P+9: luminance sum, select operands of the output scaling
    lum      = 65'(ldp_q) + 65'(lds_q);
    fin_d[0] = 64'(49'(pcwa_q) + 49'(pra_q));
    fin_d[1] = 64'(49'(pcwb_q) + 49'(pra_q));
    if (base_q[P+8].func) begin
      fin_d[2] = lum[64] ? '1 : lum[63:0];
    end else begin
      fin_d[2] = 64'(49'(pcwc_q) + 49'(prc_q));
    end
    psat_d = sat8_q | lum[64];
    // stage P+10: blue shift of chromaticity
    cha_d = 50'(base_q[P+9].comp_a) * 50'(ONE_Q16 - k_q) + 50'(k_q) * 50'(C_03);
    chb_d = 50'(base_q[P+9].comp_b) * 50'(ONE_Q16 - k_q) + 50'(k_q) * 50'(C_03);
    // stage LAST: clip and final select
    for (int i = 0; i < 3; i++) begin
      full[i]   = 97'({phi_q[i], 32'b0}) + 97'(plo_q[i]);
      clip[i]   = |full[i][96:56];
      mapped[i] = clip[i] ? '1 : full[i][55:24];
    end
    clip_xa = |cha_q[33:32];
    clip_xb = |chb_q[33:32];
    sxa     = clip_xa ? '1 : cha_q[31:0];
    sxb     = clip_xb ? '1 : chb_q[31:0];
    fb      = base_q[LAST-1];
    if (!fb.func) begin
      res_d.res_a     = mapped[0];
      res_d.res_b     = mapped[1];
      res_d.res_c     = mapped[2];
      res_d.saturated = |clip;
    end else if (fb.comp_b == '0) begin
      // zero chromaticity y: pixel passes unchanged
      res_d.res_a     = fb.comp_a;
      res_d.res_b     = fb.comp_b;
      res_d.res_c     = fb.comp_c;
      res_d.saturated = 1'b0;
    end else begin
      res_d.res_a     = sxa;
      res_d.res_b     = sxb;
      res_d.res_c     = mapped[2];
      res_d.saturated = psat2_q | clip[2] | clip_xa | clip_xb;
    end
  end

  // datapath registers, all held while stalled
  always_ff @(posedge clk_i) begin
    if (adv) begin
      base_q[1] <= in_i;
      for (int i = 2; i < LAST; i++) begin
        base_q[i] <= base_q[i-1];
      end
      wa_d_reg: begin
        wa_q <= wa_d;
        wt_q <= wt_d;
      end
      wabs_q  <= wabs_d;
      wneg_q  <= wneg_d;
      p00_q   <= p00_d;
      p01_q   <= p01_d;
      p10_q   <= p10_d;
      p11_q   <= p11_d;
      wneg1_q <= wneg_q;
      m_q     <= m_d;
      p11b_q  <= p11_q;
      wneg2_q <= wneg1_q;
      mq_q    <= mq_d;
      satw_q  <= satw_d;
      yterm_q <= yprod[48:16];
      wneg3_q <= wneg2_q;
      r_q     <= r_d;
      rsat_q  <= rsat_d;
      pr0_q   <= pr0_d;
      pr1_q   <= pr1_d;
      sat5_q  <= rsat_q;
      m0pa_q  <= m0pa_d;
      m0pb_q  <= m0pb_d;
      m0pc_q  <= m0pc_d;
      rr_q    <= rr_d;
      sat6_q  <= sat5_q | (|f_full[80:64]);
      r0_q    <= r0_d;
      lk0_q   <= lk0_d;
      lk1_q   <= lk1_d;
      sat7_q  <= sat6_q;
      s3_q    <= s3p[47:16];
      s4_q    <= s4p[47:16];
      lds_q   <= lsum[79:16];
      ldp_q   <= cprod[63:16];
      pcwa_q  <= pcwa[63:16];
      pcwb_q  <= pcwb[63:16];
      pcwc_q  <= pcwc[63:16];
      pra_q   <= prap[63:16];
      prc_q   <= prcp[63:16];
      sat8_q  <= sat7_q;
      psat_q  <= psat_d;
      psat2_q <= psat_q;
      for (int i = 0; i < 3; i++) begin
        fin_q[i] <= fin_d[i];
        plo_q[i] <= 64'(fin_q[i][31:0]) * 64'(dmr_q);
        phi_q[i] <= 64'(fin_q[i][63:32]) * 64'(dmr_q);
      end
      cha_q   <= cha_d[49:16];
      chb_q   <= chb_d[49:16];
      res_q   <= res_d;
    end
  end

  // output register and one-entry skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (take) begin
        sv_q <= 1'b0;
      end
    end else if (v_q[LAST]) begin
      if (!ov_q || take) begin
        ov_q <= 1'b1;
      end else begin
        sv_q <= 1'b1;
      end
    end else if (take) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (take) begin
        od_q <= sd_q;
      end
    end else if (v_q[LAST]) begin
      if (!ov_q || take) begin
        od_q <= res_q;
      end else begin
        sd_q <= res_q;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_o       = od_q;

  // skid only holds a result behind a waiting output
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q) else $error("skid full without output valid");

  // a finished result always lands in the output register or skid
  a_last_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LAST] && !sv_q) |=> ov_q) else $error("last stage result lost");

  // skid fills only on a stalled output
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sv_q) |-> $past(ov_q && !out_ready_i)) else $error("skid filled without stall");

  // pipeline is frozen while the skid stays full
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sv_q && !out_ready_i) |=> (sv_q && $stable(v_q))) else $error("pipeline moved under stall");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// self-checking testbench for scotopic_tone_map_pixel_unit
// depends on stm_pkg and the unit; random pixels, config phases, output back-pressure
`timescale 1ns / 100ps

module tb_top;
  import stm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 48;   // longer than the pipeline
  localparam int unsigned ITEMS_PER_PHASE = 160;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_in_t in_pix = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_out_t out_pix;

  scotopic_tone_map_pixel_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_pix),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_pix)
  );

  // clock: 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the unit's registers, reset defaults
  logic [31:0] cone_sh = 32'd65536;
  logic [31:0] rod_sh = 32'd65536;
  logic [16:0] blend_sh = 17'd65536;
  logic [31:0] recip_sh = 32'd167772;

  pix_in_t  pixel_q[$];     // pixels waiting for the driver
  pix_out_t mapped_q[$];    // predicted results in order
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 50;
  bit in_fire = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  logic clip_seen;

  // ---------------- predictor ----------------

  // exact product shifted right, pinned at the 64-bit maximum on overflow
  function automatic logic [63:0] mul_trunc(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if ((p >> (64 + sh)) != 0) begin
      clip_seen = 1'b1;
      return '1;
    end
    return p[63 + sh -: 64];
  endfunction

  function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      clip_seen = 1'b1;
      return '1;
    end
    return s[63:0];
  endfunction

  function automatic logic [31:0] to_word(logic [63:0] v);
    if (v[63:32] != 0) begin
      clip_seen = 1'b1;
      return '1;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] blue_shift(logic [31:0] v, logic [63:0] k);
    logic [63:0] t;
    t = ({32'd0, v} * (64'd65536 - k) + k * 64'(C_03)) >> 16;
    return to_word(t);
  endfunction

  function automatic pix_out_t tone_map(pix_in_t p);
    pix_out_t o;
    logic [63:0] k, a, b, c, r, cw, rw, s3, s4, q, yterm, neg, lum;
    longint rs, w;
    a = {32'd0, p.comp_a};
    b = {32'd0, p.comp_b};
    c = {32'd0, p.comp_c};
    k = (blend_sh > 17'd65536) ? 64'd65536 : {47'd0, blend_sh};
    clip_seen = 1'b0;
    if (p.func == 1'b0) begin
      rs = -longint'(C_NEG_X) * longint'(a) + longint'(C_Y) * longint'(b)
           + longint'(C_Z) * longint'(c);
      r = (rs < 0) ? 64'd0 : (64'(rs) >> 16);
      cw = ((64'd65536 - k) * {32'd0, cone_sh}) >> 16;
      rw = (k * {32'd0, rod_sh}) >> 16;
      s3 = (r * 64'(C_03)) >> 16;
      s4 = (r * 64'(C_04)) >> 16;
      o.res_a = to_word(mul_trunc(add_clip(mul_trunc(a, cw, 16), mul_trunc(s3, rw, 16)),
                                  {32'd0, recip_sh}, 24));
      o.res_b = to_word(mul_trunc(add_clip(mul_trunc(b, cw, 16), mul_trunc(s3, rw, 16)),
                                  {32'd0, recip_sh}, 24));
      o.res_c = to_word(mul_trunc(add_clip(mul_trunc(c, cw, 16), mul_trunc(s4, rw, 16)),
                                  {32'd0, recip_sh}, 24));
    end else if (b == 0) begin
      // zero chromaticity y: pixel passes through untouched
      o.res_a = p.comp_a;
      o.res_b = p.comp_b;
      o.res_c = p.comp_c;
    end else begin
      q = (c << 16) / b;
      w = -longint'(C_NEG_X) * longint'(a)
          + longint'(C_Z) * (longint'(65536) - longint'(a) - longint'(b));
      yterm = (c * 64'(C_Y)) >> 16;
      if (w >= 0) begin
        r = add_clip(yterm, mul_trunc(q, 64'(w), 32));
      end else begin
        neg = mul_trunc(q, 64'(-w), 32);
        r = (neg > yterm) ? 64'd0 : yterm - neg;
      end
      lum = add_clip(mul_trunc(c, {32'd0, cone_sh}, 16),
                     mul_trunc(mul_trunc(r, {32'd0, rod_sh}, 16), k, 16));
      o.res_c = to_word(mul_trunc(lum, {32'd0, recip_sh}, 24));
      o.res_a = blue_shift(p.comp_a, k);
      o.res_b = blue_shift(p.comp_b, k);
    end
    o.saturated = clip_seen;
    return o;
  endfunction

  // ---------------- driver / receiver ----------------

  // input side: hold the pixel until its transaction, otherwise maybe idle
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_fire) begin
        // keep offering the same pixel
      end else if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_pix <= pixel_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: random stalls plus one long hold-off counted here
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin
    pix_out_t exp_o;
    in_fire = in_valid && in_ready;
    if (rst_n) begin
      if (in_fire) mapped_q.push_back(tone_map(in_pix));
      if (out_valid && out_ready) begin
        if (mapped_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_pix);
        end else begin
          exp_o = mapped_q.pop_front();
          if (exp_o.res_a !== out_pix.res_a || exp_o.res_b !== out_pix.res_b ||
              exp_o.res_c !== out_pix.res_c || exp_o.saturated !== out_pix.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp a=%h b=%h c=%h sat=%b got a=%h b=%h c=%h sat=%b",
                       exp_o.res_a, exp_o.res_b, exp_o.res_c, exp_o.saturated,
                       out_pix.res_a, out_pix.res_b, out_pix.res_c, out_pix.saturated);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    case (idx)
      CFG_CONE_SCALE:        cone_sh = v;
      CFG_ROD_SCALE:         rod_sh = v;
      CFG_ROD_BLEND:         blend_sh = v[16:0];
      CFG_DISPLAY_MAX_RECIP: recip_sh = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] cone, logic [31:0] rod, logic [31:0] blend,
                          logic [31:0] recip);
    cfg_write(CFG_CONE_SCALE, cone);
    cfg_write(CFG_ROD_SCALE, rod);
    cfg_write(CFG_ROD_BLEND, blend);
    cfg_write(CFG_DISPLAY_MAX_RECIP, recip);
  endtask

  // luminance of assorted magnitude
  function automatic logic [31:0] rand_lum();
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom() >> $urandom_range(31);
      2: return $urandom_range(65536 * 4);
      3: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      default: return $urandom_range(65536 * 200);
    endcase
  endfunction

  // chromaticity, mostly inside Q0.16, sometimes any word, zero or exactly one
  function automatic logic [31:0] rand_chroma();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'd0;
      2: return 32'd65536;
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t p;
    p.func = $urandom_range(1);
    if (p.func) begin
      p.comp_a = rand_chroma();
      p.comp_b = rand_chroma();
      p.comp_c = rand_lum();
    end else begin
      p.comp_a = rand_lum();
      p.comp_b = rand_lum();
      p.comp_c = rand_lum();
    end
    return p;
  endfunction

  task automatic push_pixel(logic f, logic [31:0] a, logic [31:0] b, logic [31:0] c);
    pix_in_t p;
    p.func = f;
    p.comp_a = a;
    p.comp_b = b;
    p.comp_c = c;
    pixel_q.push_back(p);
  endtask

  // wait until every expected result is back, then let the pipe settle
  // checked at clock edges so a pixel just popped by the driver is already on in_valid
  task automatic drain();
    do begin
      @(posedge clk);
    end while (!(pixel_q.size() == 0 && !in_valid && mapped_q.size() == 0));
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase();
    repeat (ITEMS_PER_PHASE) pixel_q.push_back(rand_pixel());
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed pixels at reset defaults
    push_pixel(1'b0, 32'd0, 32'd0, 32'd0);
    push_pixel(1'b0, '1, '1, '1);
    push_pixel(1'b0, '1, 32'd0, 32'd0);            // negative rod response
    push_pixel(1'b0, 32'd65536, 32'd65536, 32'd65536);
    push_pixel(1'b0, 32'd0, '1, 32'd0);
    push_pixel(1'b1, 32'd20000, 32'd0, 32'd123456); // zero y passes through
    push_pixel(1'b1, '1, 32'd0, '1);
    push_pixel(1'b1, 32'd21000, 32'd21000, 32'd65536);
    push_pixel(1'b1, 32'd65535, 32'd1, '1);        // huge quotient
    push_pixel(1'b1, 32'd0, 32'd1, 32'd65536);
    push_pixel(1'b1, '1, '1, '1);
    push_pixel(1'b1, 32'd0, 32'd65535, 32'd0);
    drain();
    random_phase();

    // saturating extremes, no rod contribution
    set_regs('1, '1, 32'd0, '1);
    push_pixel(1'b0, '1, '1, '1);
    push_pixel(1'b1, 32'd1000, 32'd1, '1);
    random_phase();

    send_idle_pct = 50;
    recv_idle_pct = 36;
    // blend above one and zero reciprocal
    set_regs(32'd65536, 32'd131072, 32'h1FFFF, 32'd0);
    random_phase();

    // random settings with one long receiver hold-off
    set_regs($urandom(), $urandom(), $urandom_range(65536), $urandom_range(1, 1 << 26));
    hold_req = 1'b1;
    random_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(32'd0, 32'd0, 32'd32768, 32'd1);
    random_phase();
    set_regs($urandom_range(1 << 20), $urandom_range(1 << 20), $urandom_range(65536),
             $urandom());
    random_phase();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/stm_pkg.sv
hdl/stm_div.sv
hdl/scotopic_tone_map_pixel_unit.sv
test/tb_top.sv
